// ===== src/sse_pkg.sv =====
// shared types, constants and address helper for the semaphore set engine
package sse_pkg;

    localparam int NUM_SETS     = 8;
    localparam int SEMS_PER_SET = 8;
    localparam int MAX_BATCH    = 8;

    localparam int SET_W   = 3;
    localparam int SEM_W   = 4;
    localparam int VAL_W   = 16;
    localparam int KEY_W   = 32;
    localparam int CADDR_W = $clog2(NUM_SETS * SEMS_PER_SET);
    localparam int BIDX_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CNT_W   = $clog2(MAX_BATCH + 1);
    localparam int ZIDX_W  = (SEMS_PER_SET > 1) ? $clog2(SEMS_PER_SET) : 1;

    localparam logic [2:0] CMD_GET    = 3'd0;
    localparam logic [2:0] CMD_OP     = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_STAT   = 3'd3;
    localparam logic [2:0] CMD_SETVAL = 3'd4;
    localparam logic [2:0] CMD_GETVAL = 3'd5;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_INVALID     = 3'd1;
    localparam logic [2:0] STAT_EXISTS      = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [2:0] STAT_NO_SPACE    = 3'd4;
    localparam logic [2:0] STAT_WOULD_BLOCK = 3'd5;

    typedef struct packed {
        logic [2:0]              command;
        logic [KEY_W-1:0]        key;
        logic [SET_W-1:0]        set_id;
        logic [SEM_W-1:0]        sem_index;
        logic signed [VAL_W-1:0] op_value;
        logic [SEM_W-1:0]        set_size;
        logic                    create;
        logic                    exclusive;
        logic                    last_op;
    } sse_in_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [SET_W-1:0]        set_index_out;
        logic signed [VAL_W-1:0] counter_out;
    } sse_out_t;

    typedef struct packed {
        logic [SEM_W-1:0]        sem;
        logic signed [VAL_W-1:0] delta;
    } batch_ent_t;

    typedef struct packed {
        logic               en;
        logic [CADDR_W-1:0] addr;
        logic [VAL_W-1:0]   data;
    } ctr_wr_t;

    function automatic logic [CADDR_W-1:0] ctr_addr(input logic [SET_W-1:0] set_idx,
                                                    input logic [SEM_W-1:0] sem);
        int flat;
        flat = int'(set_idx) * SEMS_PER_SET + int'(sem);
        return flat[CADDR_W-1:0];
    endfunction

endpackage

// ===== src/sse_ctr_ram.sv =====
// counter storage: one write port, one registered read port
module sse_ctr_ram (
    input  logic                          aclk,
    input  sse_pkg::ctr_wr_t              wr,
    input  logic [sse_pkg::CADDR_W-1:0]   rd_addr,
    output logic [sse_pkg::VAL_W-1:0]     rd_data
);

    logic [sse_pkg::VAL_W-1:0] mem [sse_pkg::NUM_SETS * sse_pkg::SEMS_PER_SET];
    logic [sse_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/semaphore_set_engine.sv =====
// Semaphore set engine: a table of semaphore sets with key lookup, allocation
// and all-or-nothing op batches. One transaction is handled at a time and the
// input is not ready while it is in work; a finished result waits in the output
// register while the next transaction is taken. A get searches the keys one set
// per cycle and, when a set is allocated, zeroes its counters one per cycle
// through the single write port of the counter memory; a closing op checks
// every batch entry and then applies each through a read-modify-write of the
// same counter memory. The counter memory has no clearing pass at reset.
module semaphore_set_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sse_pkg::sse_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sse_pkg::sse_out_t m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_GET_SCAN, S_GET_ZERO, S_GV_DATA, S_BATCH_START,
        S_CHK_RD, S_CHK_CMP, S_APP_RD, S_APP_WR, S_RESP
    } state_t;

    state_t                       state_reg;
    sse_pkg::sse_in_t             in_reg;
    sse_pkg::sse_out_t            res_reg;
    sse_pkg::sse_out_t            m_data_reg;
    logic                         m_valid_reg;

    logic                         set_used_reg [sse_pkg::NUM_SETS];
    logic [sse_pkg::KEY_W-1:0]    set_key_reg  [sse_pkg::NUM_SETS];
    logic [sse_pkg::SEM_W-1:0]    set_len_reg  [sse_pkg::NUM_SETS];

    sse_pkg::batch_ent_t          batch_entry_reg [sse_pkg::MAX_BATCH];
    logic [sse_pkg::CNT_W-1:0]    batch_count_reg;
    logic [sse_pkg::SET_W-1:0]    batch_set_reg;
    logic                         batch_ovf_reg;
    logic [sse_pkg::BIDX_W-1:0]   bidx_reg;

    logic [sse_pkg::SET_W-1:0]    scan_reg;
    logic                         free_found_reg;
    logic [sse_pkg::SET_W-1:0]    free_idx_reg;
    logic [sse_pkg::ZIDX_W-1:0]   zero_reg;

    sse_pkg::ctr_wr_t             ctr_wr;
    logic [sse_pkg::CADDR_W-1:0]  rd_addr;
    logic [sse_pkg::VAL_W-1:0]    rd_data;

    sse_pkg::batch_ent_t          cur_ent;
    logic                         in_set_ok;
    logic                         in_sem_ok;
    logic                         batch_set_ok;
    logic                         last_ent;
    logic [sse_pkg::VAL_W:0]      chk_sum;
    logic                         would_block;
    logic                         key_hit;
    logic                         free_now;
    logic [sse_pkg::SET_W-1:0]    free_pick;
    logic                         scan_last;

    function automatic logic set_ok(input logic [sse_pkg::SET_W-1:0] sid);
        return (int'(sid) < sse_pkg::NUM_SETS) && set_used_reg[sid];
    endfunction

    assign cur_ent      = batch_entry_reg[bidx_reg];
    assign in_set_ok    = set_ok(in_reg.set_id);
    assign in_sem_ok    = in_reg.sem_index < set_len_reg[in_reg.set_id];
    assign batch_set_ok = set_ok(batch_set_reg);
    assign last_ent     = bidx_reg == sse_pkg::BIDX_W'(batch_count_reg - sse_pkg::CNT_W'(1));

    // counter plus delta below zero means the decrement would block; a zero delta blocks while the counter is nonzero
    assign chk_sum     = {rd_data[sse_pkg::VAL_W-1], rd_data}
                       + {cur_ent.delta[sse_pkg::VAL_W-1], cur_ent.delta};
    assign would_block = (cur_ent.delta[sse_pkg::VAL_W-1] && chk_sum[sse_pkg::VAL_W])
                       || (cur_ent.delta == '0 && rd_data != '0);

    assign key_hit   = (in_reg.key != '0) && set_used_reg[scan_reg]
                     && (set_key_reg[scan_reg] == in_reg.key);
    assign free_now  = free_found_reg || !set_used_reg[scan_reg];
    assign free_pick = free_found_reg ? free_idx_reg : scan_reg;
    assign scan_last = scan_reg == sse_pkg::SET_W'(sse_pkg::NUM_SETS - 1);

    assign rd_addr = (state_reg == S_DISPATCH)
                   ? sse_pkg::ctr_addr(in_reg.set_id, in_reg.sem_index)
                   : sse_pkg::ctr_addr(batch_set_reg, cur_ent.sem);

    always_comb begin
        ctr_wr = '0;
        case (state_reg)
            S_GET_ZERO: begin
                ctr_wr.en   = 1'b1;
                ctr_wr.addr = sse_pkg::ctr_addr(free_idx_reg,
                                                sse_pkg::SEM_W'(zero_reg));
            end
            S_DISPATCH: begin
                ctr_wr.en   = (in_reg.command == sse_pkg::CMD_SETVAL)
                            && in_set_ok && in_sem_ok;
                ctr_wr.addr = rd_addr;
                ctr_wr.data = in_reg.op_value;
            end
            S_APP_WR: begin
                ctr_wr.en   = 1'b1;
                ctr_wr.addr = rd_addr;
                ctr_wr.data = rd_data + cur_ent.delta;
            end
            default: begin
                ctr_wr = '0;
            end
        endcase
    end

    sse_ctr_ram u_ctr_ram (
        .aclk    (aclk),
        .wr      (ctr_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            batch_count_reg <= '0;
            batch_set_reg   <= '0;
            batch_ovf_reg   <= 1'b0;
            for (int i = 0; i < sse_pkg::NUM_SETS; i++) begin
                set_used_reg[i] <= 1'b0;
            end
        end else begin
            // the response state handles the output register itself
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    res_reg.set_index_out <= '0;
                    res_reg.counter_out   <= '0;
                    if (in_reg.command == sse_pkg::CMD_OP) begin
                        res_reg.status <= sse_pkg::STAT_INVALID;
                        if (batch_count_reg == '0 && !batch_ovf_reg) begin
                            batch_set_reg <= in_reg.set_id;
                        end
                        if (int'(batch_count_reg) < sse_pkg::MAX_BATCH) begin
                            batch_entry_reg[batch_count_reg[sse_pkg::BIDX_W-1:0]] <=
                                '{sem: in_reg.sem_index, delta: in_reg.op_value};
                            batch_count_reg <= batch_count_reg + sse_pkg::CNT_W'(1);
                        end else begin
                            batch_ovf_reg <= 1'b1;
                        end
                        state_reg <= in_reg.last_op ? S_BATCH_START : S_IDLE;
                    end else begin
                        batch_count_reg <= '0;
                        batch_ovf_reg   <= 1'b0;
                        case (in_reg.command)
                            sse_pkg::CMD_GET: begin
                                res_reg.status <= sse_pkg::STAT_INVALID;
                                if (int'(in_reg.set_size) <= sse_pkg::SEMS_PER_SET) begin
                                    scan_reg       <= '0;
                                    free_found_reg <= 1'b0;
                                    state_reg      <= S_GET_SCAN;
                                end else begin
                                    state_reg <= S_RESP;
                                end
                            end
                            sse_pkg::CMD_REMOVE: begin
                                if (in_set_ok) begin
                                    set_used_reg[in_reg.set_id] <= 1'b0;
                                end
                                res_reg.status <= in_set_ok ? sse_pkg::STAT_OK
                                                            : sse_pkg::STAT_INVALID;
                                state_reg      <= S_RESP;
                            end
                            sse_pkg::CMD_STAT: begin
                                res_reg.status <= in_set_ok ? sse_pkg::STAT_OK
                                                            : sse_pkg::STAT_INVALID;
                                state_reg      <= S_RESP;
                            end
                            sse_pkg::CMD_SETVAL: begin
                                res_reg.status <= (in_set_ok && in_sem_ok)
                                                ? sse_pkg::STAT_OK : sse_pkg::STAT_INVALID;
                                state_reg      <= S_RESP;
                            end
                            sse_pkg::CMD_GETVAL: begin
                                if (in_set_ok && in_sem_ok) begin
                                    res_reg.status <= sse_pkg::STAT_OK;
                                    state_reg      <= S_GV_DATA;
                                end else begin
                                    res_reg.status <= sse_pkg::STAT_INVALID;
                                    state_reg      <= S_RESP;
                                end
                            end
                            default: begin
                                res_reg.status <= sse_pkg::STAT_INVALID;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_GV_DATA: begin
                    res_reg.counter_out <= rd_data;
                    state_reg           <= S_RESP;
                end
                S_GET_SCAN: begin
                    if (key_hit) begin
                        if (in_reg.create && in_reg.exclusive) begin
                            res_reg.status <= sse_pkg::STAT_EXISTS;
                        end else begin
                            res_reg.status        <= sse_pkg::STAT_OK;
                            res_reg.set_index_out <= scan_reg;
                        end
                        state_reg <= S_RESP;
                    end else if (scan_last) begin
                        if (in_reg.key != '0 && !in_reg.create) begin
                            res_reg.status <= sse_pkg::STAT_NOT_FOUND;
                            state_reg      <= S_RESP;
                        end else if (free_now) begin
                            set_used_reg[free_pick] <= 1'b1;
                            set_key_reg[free_pick]  <= in_reg.key;
                            set_len_reg[free_pick]  <= in_reg.set_size;
                            free_idx_reg            <= free_pick;
                            zero_reg                <= '0;
                            res_reg.status          <= sse_pkg::STAT_OK;
                            res_reg.set_index_out   <= free_pick;
                            state_reg               <= S_GET_ZERO;
                        end else begin
                            res_reg.status <= sse_pkg::STAT_NO_SPACE;
                            state_reg      <= S_RESP;
                        end
                    end else begin
                        scan_reg       <= scan_reg + sse_pkg::SET_W'(1);
                        free_found_reg <= free_now;
                        free_idx_reg   <= free_pick;
                    end
                end
                S_GET_ZERO: begin
                    zero_reg <= zero_reg + sse_pkg::ZIDX_W'(1);
                    if (zero_reg == sse_pkg::ZIDX_W'(sse_pkg::SEMS_PER_SET - 1)) begin
                        state_reg <= S_RESP;
                    end
                end
                S_BATCH_START: begin
                    bidx_reg <= '0;
                    if (batch_ovf_reg || !batch_set_ok) begin
                        batch_count_reg <= '0;
                        batch_ovf_reg   <= 1'b0;
                        state_reg       <= S_RESP;
                    end else begin
                        state_reg <= S_CHK_RD;
                    end
                end
                S_CHK_RD: begin
                    if (cur_ent.sem >= set_len_reg[batch_set_reg]) begin
                        batch_count_reg <= '0;
                        state_reg       <= S_RESP;
                    end else begin
                        state_reg <= S_CHK_CMP;
                    end
                end
                S_CHK_CMP: begin
                    if (would_block) begin
                        res_reg.status  <= sse_pkg::STAT_WOULD_BLOCK;
                        batch_count_reg <= '0;
                        state_reg       <= S_RESP;
                    end else if (last_ent) begin
                        bidx_reg  <= '0;
                        state_reg <= S_APP_RD;
                    end else begin
                        bidx_reg  <= bidx_reg + sse_pkg::BIDX_W'(1);
                        state_reg <= S_CHK_RD;
                    end
                end
                S_APP_RD: begin
                    state_reg <= S_APP_WR;
                end
                S_APP_WR: begin
                    if (last_ent) begin
                        res_reg.status  <= sse_pkg::STAT_OK;
                        batch_count_reg <= '0;
                        state_reg       <= S_RESP;
                    end else begin
                        bidx_reg  <= bidx_reg + sse_pkg::BIDX_W'(1);
                        state_reg <= S_APP_RD;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/sse_checker.sv =====
// port-level checks for the semaphore set engine, bound to the top level
module sse_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sse_pkg::sse_out_t m_data
);

    // the input is not ready in the cycle after an acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted transaction");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // only a successful get reports a set index, only get value a counter
    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != sse_pkg::STAT_OK
        |-> m_data.set_index_out == '0 && m_data.counter_out == '0)
        else $error("failed transaction carries nonzero fields");

    a_fields_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.set_index_out == '0 || m_data.counter_out == '0)
        else $error("set index and counter value both nonzero");

endmodule

bind semaphore_set_engine sse_checker u_sse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/tb_semaphore_set_engine.sv =====
// self-checking testbench for the semaphore set engine: directed table plus random traffic
`timescale 1ns / 100ps

module tb_semaphore_set_engine;

    // command codes the package leaves unnamed
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        sse_pkg::sse_in_t  req;
        bit                fixed;
        sse_pkg::sse_out_t reply;
    } plan_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    sse_pkg::sse_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    sse_pkg::sse_out_t m_data;

    // shadow copy of the set table
    bit                               sem_set_used [sse_pkg::NUM_SETS];
    logic [sse_pkg::KEY_W-1:0]        sem_set_key  [sse_pkg::NUM_SETS];
    logic [sse_pkg::SEM_W-1:0]        sem_set_len  [sse_pkg::NUM_SETS];
    logic signed [sse_pkg::VAL_W-1:0] sem_count    [sse_pkg::NUM_SETS*sse_pkg::SEMS_PER_SET];

    // op batch collected so far
    logic [sse_pkg::SEM_W-1:0]        pend_sem   [sse_pkg::MAX_BATCH];
    logic signed [sse_pkg::VAL_W-1:0] pend_delta [sse_pkg::MAX_BATCH];
    int                               pend_count    = 0;
    logic [sse_pkg::SET_W-1:0]        pend_set      = '0;
    bit                               pend_overflow = 1'b0;

    sse_pkg::sse_out_t pending_replies[$];
    plan_row_t         plan[$];
    sse_pkg::sse_out_t want;
    int                errors    = 0;
    int                reqs_sent = 0;
    bit                calm      = 1'b0;

    semaphore_set_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit set_live(input logic [sse_pkg::SET_W-1:0] sid);
        return int'(sid) < sse_pkg::NUM_SETS && sem_set_used[sid];
    endfunction

    function automatic void predict_reply(input sse_pkg::sse_in_t req, output bit has,
                                          output sse_pkg::sse_out_t rep);
        int d;
        int v;
        int k;
        int slot;
        has = 1'b1;
        rep = '0;
        rep.status = sse_pkg::STAT_INVALID;
        if (req.command == sse_pkg::CMD_OP) begin
            if (pend_count == 0 && !pend_overflow) begin
                pend_set = req.set_id;
            end
            if (pend_count < sse_pkg::MAX_BATCH) begin
                pend_sem[pend_count]   = req.sem_index;
                pend_delta[pend_count] = req.op_value;
                pend_count++;
            end else begin
                pend_overflow = 1'b1;
            end
            if (!req.last_op) begin
                has = 1'b0;
                return;
            end
            rep.status = sse_pkg::STAT_OK;
            if (pend_overflow || !set_live(pend_set)) begin
                rep.status = sse_pkg::STAT_INVALID;
            end else begin
                // every entry sees the counters as they were before the batch
                for (int i = 0; i < pend_count; i++) begin
                    if (rep.status == sse_pkg::STAT_OK) begin
                        if (pend_sem[i] >= sem_set_len[pend_set]) begin
                            rep.status = sse_pkg::STAT_INVALID;
                        end else begin
                            k = int'(pend_set) * sse_pkg::SEMS_PER_SET + int'(pend_sem[i]);
                            v = int'(sem_count[k]);
                            d = int'(pend_delta[i]);
                            if ((d < 0 && v < -d) || (d == 0 && v != 0)) begin
                                rep.status = sse_pkg::STAT_WOULD_BLOCK;
                            end
                        end
                    end
                end
                if (rep.status == sse_pkg::STAT_OK) begin
                    for (int i = 0; i < pend_count; i++) begin
                        k = int'(pend_set) * sse_pkg::SEMS_PER_SET + int'(pend_sem[i]);
                        sem_count[k] = sem_count[k] + pend_delta[i];
                    end
                end
            end
            pend_count    = 0;
            pend_overflow = 1'b0;
        end else begin
            pend_count    = 0;
            pend_overflow = 1'b0;
            k = int'(req.set_id) * sse_pkg::SEMS_PER_SET + int'(req.sem_index);
            case (req.command)
                sse_pkg::CMD_GET: begin
                    slot = -1;
                    if (int'(req.set_size) > sse_pkg::SEMS_PER_SET) begin
                        rep.status = sse_pkg::STAT_INVALID;
                    end else begin
                        if (req.key != '0) begin
                            for (int i = 0; i < sse_pkg::NUM_SETS; i++) begin
                                if (slot < 0 && sem_set_used[i]
                                    && sem_set_key[i] == req.key) begin
                                    slot = i;
                                end
                            end
                        end
                        if (slot >= 0) begin
                            if (req.create && req.exclusive) begin
                                rep.status = sse_pkg::STAT_EXISTS;
                            end else begin
                                rep.status        = sse_pkg::STAT_OK;
                                rep.set_index_out = sse_pkg::SET_W'(slot);
                            end
                        end else if (req.key != '0 && !req.create) begin
                            rep.status = sse_pkg::STAT_NOT_FOUND;
                        end else begin
                            for (int i = 0; i < sse_pkg::NUM_SETS; i++) begin
                                if (slot < 0 && !sem_set_used[i]) begin
                                    slot = i;
                                end
                            end
                            if (slot < 0) begin
                                rep.status = sse_pkg::STAT_NO_SPACE;
                            end else begin
                                sem_set_used[slot] = 1'b1;
                                sem_set_key[slot]  = req.key;
                                sem_set_len[slot]  = req.set_size;
                                for (int j = 0; j < sse_pkg::SEMS_PER_SET; j++) begin
                                    sem_count[slot*sse_pkg::SEMS_PER_SET+j] = '0;
                                end
                                rep.status        = sse_pkg::STAT_OK;
                                rep.set_index_out = sse_pkg::SET_W'(slot);
                            end
                        end
                    end
                end
                sse_pkg::CMD_REMOVE: begin
                    if (set_live(req.set_id)) begin
                        sem_set_used[req.set_id] = 1'b0;
                        rep.status = sse_pkg::STAT_OK;
                    end
                end
                sse_pkg::CMD_STAT: begin
                    if (set_live(req.set_id)) begin
                        rep.status = sse_pkg::STAT_OK;
                    end
                end
                sse_pkg::CMD_SETVAL: begin
                    if (set_live(req.set_id) && req.sem_index < sem_set_len[req.set_id]) begin
                        sem_count[k] = req.op_value;
                        rep.status   = sse_pkg::STAT_OK;
                    end
                end
                sse_pkg::CMD_GETVAL: begin
                    if (set_live(req.set_id) && req.sem_index < sem_set_len[req.set_id]) begin
                        rep.counter_out = sem_count[k];
                        rep.status      = sse_pkg::STAT_OK;
                    end
                end
                default: begin
                    rep.status = sse_pkg::STAT_INVALID;
                end
            endcase
        end
    endfunction

    function automatic int draw_gap();
        if (calm) begin
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic sse_pkg::sse_in_t req_of(input logic [2:0] cmd,
                                                input logic [sse_pkg::KEY_W-1:0] key,
                                                input int sid, input int idx,
                                                input int val, input int size,
                                                input int cr, input int ex,
                                                input int last);
        sse_pkg::sse_in_t r;
        r.command   = cmd;
        r.key       = key;
        r.set_id    = sse_pkg::SET_W'(sid);
        r.sem_index = sse_pkg::SEM_W'(idx);
        r.op_value  = sse_pkg::VAL_W'(val);
        r.set_size  = sse_pkg::SEM_W'(size);
        r.create    = cr != 0;
        r.exclusive = ex != 0;
        r.last_op   = last != 0;
        return r;
    endfunction

    function automatic sse_pkg::sse_out_t reply_of(input logic [2:0] st, input int si,
                                                   input int cnt);
        sse_pkg::sse_out_t r;
        r.status        = st;
        r.set_index_out = sse_pkg::SET_W'(si);
        r.counter_out   = sse_pkg::VAL_W'(cnt);
        return r;
    endfunction

    function automatic void add_row(input sse_pkg::sse_in_t req, input bit fixed,
                                    input sse_pkg::sse_out_t reply);
        plan_row_t row;
        row.req   = req;
        row.fixed = fixed;
        row.reply = reply;
        plan.push_back(row);
    endfunction

    // unused fields carry noise so every bit moves
    function automatic sse_pkg::sse_in_t random_fields();
        sse_pkg::sse_in_t r;
        r.command   = 3'($urandom_range(0, 7));
        r.key       = $urandom;
        r.set_id    = 3'($urandom_range(0, 7));
        r.sem_index = 4'($urandom_range(0, 15));
        r.op_value  = 16'($urandom);
        r.set_size  = 4'($urandom_range(0, 15));
        r.create    = 1'($urandom_range(0, 1));
        r.exclusive = 1'($urandom_range(0, 1));
        r.last_op   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [sse_pkg::SET_W-1:0] pick_set();
        logic [sse_pkg::SET_W-1:0] live[$];
        for (int i = 0; i < sse_pkg::NUM_SETS; i++) begin
            if (sem_set_used[i]) begin
                live.push_back(3'(i));
            end
        end
        if (live.size() == 0 || $urandom_range(0, 4) == 0) begin
            return 3'($urandom_range(0, 7));
        end
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [sse_pkg::SEM_W-1:0] pick_index(
            input logic [sse_pkg::SET_W-1:0] sid);
        if (sem_set_used[sid] && sem_set_len[sid] != 0 && $urandom_range(0, 7) != 0) begin
            return 4'($urandom_range(0, int'(sem_set_len[sid]) - 1));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    // offer one transaction, then book its reply once accepted
    task automatic issue(input sse_pkg::sse_in_t req, input bit fixed,
                         input sse_pkg::sse_out_t fixed_reply);
        int                gap;
        bit                has;
        sse_pkg::sse_out_t rep;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_reply(req, has, rep);
        if (has) begin
            pending_replies.push_back(fixed ? fixed_reply : rep);
        end
        reqs_sent++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t ns: unexpected result, status %0d set %0d counter %0d",
                         $time, m_data.status, m_data.set_index_out, m_data.counter_out);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t ns: status expected %0d, got %0d",
                             $time, want.status, m_data.status);
                    errors++;
                end
                if (m_data.set_index_out !== want.set_index_out) begin
                    $display("%0t ns: set index expected %0d, got %0d",
                             $time, want.set_index_out, m_data.set_index_out);
                    errors++;
                end
                if (m_data.counter_out !== want.counter_out) begin
                    $display("%0t ns: counter expected %0d, got %0d",
                             $time, want.counter_out, m_data.counter_out);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls, one long hold-off so the block backs up
    initial begin
        int gap;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken == HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin
        sse_pkg::sse_in_t          req;
        logic [sse_pkg::SET_W-1:0] sid;
        int                        n;
        int                        v;
        int                        choice;
        int                        next_flip;
        bit                        cut;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_row(req_of(sse_pkg::CMD_STAT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        add_row(req_of(sse_pkg::CMD_GET, 0, 0, 0, 0, 15, 1, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        add_row(req_of(sse_pkg::CMD_GET, 32'hFFFF_FFFF, 0, 0, 0, 8, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_NOT_FOUND, 0, 0));
        add_row(req_of(sse_pkg::CMD_GET, 32'hFFFF_FFFF, 0, 0, 0, 8, 1, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 0));
        add_row(req_of(sse_pkg::CMD_GET, 32'hFFFF_FFFF, 0, 0, 0, 8, 1, 1, 0), 1'b1,
                reply_of(sse_pkg::STAT_EXISTS, 0, 0));
        add_row(req_of(sse_pkg::CMD_GET, 32'hFFFF_FFFF, 0, 0, 0, 3, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 0));
        // private key always takes a fresh set, here with no counters
        add_row(req_of(sse_pkg::CMD_GET, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 1, 0));
        add_row(req_of(sse_pkg::CMD_SETVAL, 0, 0, 7, 32767, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 0));
        add_row(req_of(sse_pkg::CMD_GETVAL, 0, 0, 7, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 32767));
        add_row(req_of(sse_pkg::CMD_GETVAL, 0, 7, 15, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        // set id of later batch items is ignored
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 0, 5, 0, 0, 0, 0), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_OP, 0, 7, 7, -1, 0, 0, 0, 1), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 7, 2, 0, 0, 0, 1), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_GETVAL, 0, 0, 7, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                reply_of(sse_pkg::STAT_WOULD_BLOCK, 0, 0));
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 1, -32768, 0, 0, 0, 1), 1'b1,
                reply_of(sse_pkg::STAT_WOULD_BLOCK, 0, 0));
        // first failing entry decides
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 8, 1, 0, 0, 0, 0), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 1, -1, 0, 0, 0, 1), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        add_row(req_of(sse_pkg::CMD_OP, 0, 1, 0, 1, 0, 0, 0, 1), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        // unfinished batch dropped by another command
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 2, 3, 0, 0, 0, 0), 1'b0, '0);
        add_row(req_of(sse_pkg::CMD_STAT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 0));
        add_row(req_of(sse_pkg::CMD_OP, 0, 0, 0, -5, 0, 0, 0, 1), 1'b0, '0);
        for (int b = 0; b <= sse_pkg::MAX_BATCH; b++) begin
            add_row(req_of(sse_pkg::CMD_OP, 0, 0, 2, 1, 0, 0, 0,
                           int'(b == sse_pkg::MAX_BATCH)), 1'b1,
                    reply_of(sse_pkg::STAT_INVALID, 0, 0));
        end
        add_row(req_of(CMD_RSVD_A, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        add_row(req_of(CMD_RSVD_B, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));
        add_row(req_of(sse_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_OK, 0, 0));
        add_row(req_of(sse_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                reply_of(sse_pkg::STAT_INVALID, 0, 0));

        foreach (plan[r]) begin
            issue(plan[r].req, plan[r].fixed, plan[r].reply);
        end

        next_flip = 0;
        while (reqs_sent < plan.size() + RANDOM_ITEMS) begin
            if (reqs_sent >= next_flip) begin
                calm      = ($urandom_range(0, 3) == 0);
                next_flip = reqs_sent + 100;
            end
            choice = int'($urandom_range(0, 99));
            if (choice < 40) begin
                // op batch on a set that mostly exists, sometimes left open
                sid = pick_set();
                case ($urandom_range(0, 19))
                    0:       n = sse_pkg::MAX_BATCH + int'($urandom_range(1, 3));
                    1:       n = sse_pkg::MAX_BATCH;
                    default: n = int'($urandom_range(1, 4));
                endcase
                cut = ($urandom_range(0, 14) == 0);
                for (int e = 0; e < n; e++) begin
                    req         = random_fields();
                    req.command = sse_pkg::CMD_OP;
                    if (e == 0) begin
                        req.set_id = sid;
                    end
                    req.sem_index = pick_index(sid);
                    v = 0;
                    if (sem_set_used[sid] && req.sem_index < sem_set_len[sid]) begin
                        v = int'(sem_count[int'(sid) * sse_pkg::SEMS_PER_SET
                                           + int'(req.sem_index)]);
                    end
                    case ($urandom_range(0, 5))
                        0, 1:    req.op_value = 16'($urandom_range(1, 20));
                        2:       req.op_value = -16'($urandom_range(1, 4));
                        3:       req.op_value = '0;
                        4:       req.op_value = 16'(-v);
                        default: req.op_value = 16'($urandom);
                    endcase
                    req.last_op = (e == n - 1) && !cut;
                    issue(req, 1'b0, '0);
                end
            end else begin
                req = random_fields();
                if (choice < 60) begin
                    req.command = sse_pkg::CMD_GET;
                    case ($urandom_range(0, 5))
                        0:       req.key = '0;
                        1:       req.key = $urandom;
                        default: req.key = 32'hC0DE_0000 | $urandom_range(1, 5);
                    endcase
                    req.set_size  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                                 : 4'($urandom_range(0, 8));
                    req.create    = ($urandom_range(0, 3) != 0);
                    req.exclusive = ($urandom_range(0, 2) == 0);
                end else if (choice < 70) begin
                    req.command = sse_pkg::CMD_REMOVE;
                    req.set_id  = pick_set();
                end else if (choice < 75) begin
                    req.command = sse_pkg::CMD_STAT;
                    req.set_id  = pick_set();
                end else if (choice < 85) begin
                    req.command   = sse_pkg::CMD_SETVAL;
                    req.set_id    = pick_set();
                    req.sem_index = pick_index(req.set_id);
                    if ($urandom_range(0, 1) == 0) begin
                        req.op_value = 16'($urandom_range(0, 40));
                    end
                end else if (choice < 97) begin
                    req.command   = sse_pkg::CMD_GETVAL;
                    req.set_id    = pick_set();
                    req.sem_index = pick_index(req.set_id);
                end else begin
                    req.command = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
                end
                issue(req, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        // a trailing open batch may still be in work
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
